// ----- rtl/rpa_pkg.sv -----
// Shared types and codes for the reference-counted page allocator.
// No dependencies; used by refcounted_page_allocator.
package rpa_pkg;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned PAGE_W   = 15;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned REF_W    = 8;

    // command codes (codes 5 to 7 act as a count read)
    localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INCR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DECR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] STS_BAD_PAGE  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_ZERO      = 3'd3;
    localparam logic [STATUS_W-1:0] STS_SATURATED = 3'd4;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

// ----- rtl/refcounted_page_allocator.sv -----
// Reference-counted page allocator: LIFO free stack plus a count table.
// Both live in single-port-write synchronous memories; depends on rpa_pkg.
// An accepted request is latched with its memory reads and executes once the response
// register is free or being taken, which then loads the response register. No new
// request is accepted until it has executed, set by the read-then-write access to the count
// memory. After reset the count memory is zeroed one entry per cycle, before any request.
module refcounted_page_allocator #(
    parameter int unsigned NUM_PAGES   = 32768,
    parameter int unsigned COUNT_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: first_free_page
    input  logic        i_cfg_wr_en,
    input  logic [14:0] i_cfg_wr_data,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [2:0] cmd, [17:3] page_index, [23:18] zero
    // response stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [2:0] status, [17:3] result_page,
                                     // [25:18] ref_count, [26] page_released,
                                     // [31:27] zero
);

    // page address width, stack depth / untouched-top width, compare width
    localparam int unsigned PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int unsigned DW = $clog2(NUM_PAGES + 1);
    localparam int unsigned AW = ((PW > rpa_pkg::PAGE_W) ? PW : rpa_pkg::PAGE_W) + 1;
    localparam int unsigned XW = PW + rpa_pkg::PAGE_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    logic [COUNT_WIDTH-1:0]      r_cnt_mem [NUM_PAGES];
    logic [rpa_pkg::PAGE_W-1:0]  r_stk_mem [NUM_PAGES];
    logic [COUNT_WIDTH-1:0]      r_cnt_rd;
    logic [rpa_pkg::PAGE_W-1:0]  r_stk_rd;

    rpa_pkg::t_state             r_state, n_state;
    logic [PW-1:0]               r_clr_addr;
    logic [rpa_pkg::PAGE_W-1:0]  r_first_free;
    logic [DW-1:0]               r_stack_depth, n_stack_depth;
    logic [DW-1:0]               r_untouched, n_untouched;

    // request latched at accept
    logic [rpa_pkg::CMD_W-1:0]   r_cmd;
    logic [rpa_pkg::PAGE_W-1:0]  r_pg;

    // response register
    logic                        r_out_valid, n_out_valid;
    logic [rpa_pkg::STATUS_W-1:0] r_status, n_status;
    logic [rpa_pkg::PAGE_W-1:0]  r_res_page, n_res_page;
    logic [rpa_pkg::REF_W-1:0]   r_ref, n_ref;
    logic                        r_released, n_released;

    // ------------------------------------------------------------------
    // Control decode
    // ------------------------------------------------------------------
    logic                        w_accept;
    logic                        w_exec_go;
    logic                        w_clear_we;
    logic                        w_clear_done;

    logic [rpa_pkg::CMD_W-1:0]   w_in_cmd;
    logic [rpa_pkg::PAGE_W-1:0]  w_in_pg;
    logic [XW-1:0]               w_in_pg_x;
    logic [PW-1:0]               w_in_addr;
    logic [PW-1:0]               w_stk_top_addr;

    assign w_in_cmd  = i_s_tdata[2:0];
    assign w_in_pg   = i_s_tdata[17:3];
    assign w_in_pg_x = XW'(w_in_pg);
    assign w_in_addr = w_in_pg_x[PW-1:0];
    assign w_stk_top_addr = PW'(r_stack_depth - DW'(1));

    assign w_accept     = i_s_tvalid && o_s_tready;
    assign w_exec_go    = (r_state == rpa_pkg::ST_EXEC) && (!r_out_valid || i_m_tready);
    assign w_clear_done = (r_clr_addr == PW'(NUM_PAGES - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rpa_pkg::ST_CLEAR: begin
                if (w_clear_done) n_state = rpa_pkg::ST_IDLE;
            end
            rpa_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = rpa_pkg::ST_EXEC;
            end
            rpa_pkg::ST_EXEC: begin
                if (w_exec_go) n_state = rpa_pkg::ST_IDLE;
            end
            default: n_state = rpa_pkg::ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        w_clear_we = 1'b0;
        unique case (r_state)
            rpa_pkg::ST_CLEAR: w_clear_we = 1'b1;
            rpa_pkg::ST_IDLE:  o_s_tready = 1'b1;
            rpa_pkg::ST_EXEC:  o_s_tready = 1'b0;
            default:           o_s_tready = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Execute: operate on the count read back from memory
    // ------------------------------------------------------------------
    logic [AW-1:0]               w_pg_x;
    logic [AW-1:0]               w_first_x;
    logic [AW-1:0]               w_top_x;
    logic                        w_in_table;
    logic                        w_bad;
    logic [XW-1:0]               w_pg_ext;
    logic [XW-1:0]               w_stk_ext;
    logic [PW-1:0]               w_pg_addr;
    logic [PW-1:0]               w_got;
    logic [DW-1:0]               w_top_dec;
    logic [COUNT_WIDTH-1:0]      w_cnt_dec;
    logic [COUNT_WIDTH-1:0]      w_cnt_inc;
    logic [COUNT_WIDTH-1:0]      w_ref_val;

    logic                        w_cnt_we;
    logic [PW-1:0]               w_cnt_waddr;
    logic [COUNT_WIDTH-1:0]      w_cnt_wdata;
    logic                        w_stk_we;

    assign w_pg_x    = AW'(r_pg);
    assign w_first_x = AW'(r_first_free);
    assign w_top_x   = AW'(r_untouched);
    assign w_in_table = w_pg_x < AW'(NUM_PAGES);
    assign w_bad = !w_in_table || ((r_cmd == rpa_pkg::CMD_FREE) && (w_pg_x < w_first_x));
    assign w_pg_ext  = XW'(r_pg);
    assign w_stk_ext = XW'(r_stk_rd);
    assign w_pg_addr = w_pg_ext[PW-1:0];
    assign w_top_dec = r_untouched - DW'(1);
    assign w_cnt_dec = r_cnt_rd - COUNT_WIDTH'(1);
    assign w_cnt_inc = r_cnt_rd + COUNT_WIDTH'(1);

    always_comb begin
        n_stack_depth = r_stack_depth;
        n_untouched   = r_untouched;
        n_status      = r_status;
        n_res_page    = r_res_page;
        n_released    = r_released;
        n_ref         = r_ref;
        w_ref_val     = '0;
        w_got         = w_pg_addr;
        w_cnt_we      = 1'b0;
        w_cnt_waddr   = w_pg_addr;
        w_cnt_wdata   = '0;
        w_stk_we      = 1'b0;

        if (w_clear_we) begin
            w_cnt_we    = 1'b1;
            w_cnt_waddr = r_clr_addr;
        end else if (w_exec_go) begin
            n_status   = rpa_pkg::STS_OK;
            n_res_page = r_pg;
            n_released = 1'b0;
            if (r_cmd == rpa_pkg::CMD_ALLOC) begin
                // pop the stack first, else carve from the untouched top
                if (r_stack_depth != '0) begin
                    n_stack_depth = r_stack_depth - DW'(1);
                    w_got         = w_stk_ext[PW-1:0];
                    w_cnt_we      = 1'b1;
                end else if (w_top_x > w_first_x) begin
                    n_untouched   = w_top_dec;
                    w_got         = PW'(w_top_dec);
                    w_cnt_we      = 1'b1;
                end else begin
                    n_status      = rpa_pkg::STS_EMPTY;
                end
                w_cnt_waddr = w_got;
                w_cnt_wdata = COUNT_WIDTH'(1);
                if (w_cnt_we) begin
                    n_res_page = rpa_pkg::PAGE_W'(w_got);
                    w_ref_val  = COUNT_WIDTH'(1);
                end else begin
                    n_res_page = '0;
                end
            end else if (w_bad) begin
                n_status = rpa_pkg::STS_BAD_PAGE;
            end else begin
                case (r_cmd)
                    rpa_pkg::CMD_FREE: begin
                        if (r_cnt_rd == '0) begin
                            n_status = rpa_pkg::STS_ZERO;
                        end else begin
                            w_cnt_we    = 1'b1;
                            w_cnt_wdata = w_cnt_dec;
                            w_ref_val   = w_cnt_dec;
                            // push on the last reference unless the stack is full
                            if (w_cnt_dec == '0 && r_stack_depth != DW'(NUM_PAGES)) begin
                                w_stk_we      = 1'b1;
                                n_stack_depth = r_stack_depth + DW'(1);
                                n_released    = 1'b1;
                            end
                        end
                    end
                    rpa_pkg::CMD_INCR: begin
                        if (r_cnt_rd == CNT_MAX) begin
                            n_status  = rpa_pkg::STS_SATURATED;
                            w_ref_val = r_cnt_rd;
                        end else begin
                            w_cnt_we    = 1'b1;
                            w_cnt_wdata = w_cnt_inc;
                            w_ref_val   = w_cnt_inc;
                        end
                    end
                    rpa_pkg::CMD_DECR: begin
                        if (r_cnt_rd == '0) begin
                            n_status = rpa_pkg::STS_ZERO;
                        end else begin
                            w_cnt_we    = 1'b1;
                            w_cnt_wdata = w_cnt_dec;
                            w_ref_val   = w_cnt_dec;
                        end
                    end
                    default: w_ref_val = r_cnt_rd;
                endcase
            end
            // report the low bits of the count
            n_ref = rpa_pkg::REF_W'(w_ref_val);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_exec_go)       n_out_valid = 1'b1;
        else if (i_m_tready) n_out_valid = 1'b0;
    end

    // ------------------------------------------------------------------
    // Memories: zeroed while clearing, read at accept, write back when the request executes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_cnt_we) r_cnt_mem[w_cnt_waddr] <= w_cnt_wdata;
        if (w_accept) r_cnt_rd <= r_cnt_mem[w_in_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_stk_we) r_stk_mem[r_stack_depth[PW-1:0]] <= r_pg;
        if (w_accept) r_stk_rd <= r_stk_mem[w_stk_top_addr];
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= rpa_pkg::ST_CLEAR;
            r_clr_addr    <= '0;
            r_first_free  <= '0;
            r_stack_depth <= '0;
            r_untouched   <= DW'(NUM_PAGES);
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_stack_depth <= n_stack_depth;
            r_untouched   <= n_untouched;
            r_out_valid   <= n_out_valid;
            if (w_clear_we) r_clr_addr <= r_clr_addr + PW'(1);
            if (i_cfg_wr_en) r_first_free <= i_cfg_wr_data;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= w_in_cmd;
            r_pg  <= w_in_pg;
        end
        r_status   <= n_status;
        r_res_page <= n_res_page;
        r_ref      <= n_ref;
        r_released <= n_released;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_released, r_ref, r_res_page, r_status};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stack_depth <= DW'(NUM_PAGES))
        else $error("free stack depth beyond capacity");

    a_top_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_untouched <= $past(r_untouched))
        else $error("untouched top moved upward");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpa_pkg::ST_CLEAR) |-> !o_s_tready)
        else $error("request accepted during count clear");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == rpa_pkg::ST_EXEC))
        else $error("accepted request did not enter execute");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for refcounted_page_allocator: request stream in, response stream out.
// Needs rpa_pkg and the allocator RTL; a scoreboard class keeps its own copy of the
// count table, the free stack and the allocation frontier.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned NUM_PAGES    = 32768;
    localparam int unsigned COUNT_WIDTH  = 8;
    localparam int unsigned ITEMS        = 1350;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    // extra settling time after the last response, before a configuration write
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned LIVE_DEPTH   = 48;

    localparam logic [rpa_pkg::REF_W-1:0]  COUNT_MAX = '1;
    localparam logic [rpa_pkg::PAGE_W-1:0] TOP_PAGE  = rpa_pkg::PAGE_W'(NUM_PAGES - 1);
    // codes above CMD_READ are undefined and behave as a count read
    localparam int unsigned CMD_SPARE_FIRST = rpa_pkg::CMD_READ + 1;
    localparam int unsigned CMD_CODES       = 2 ** rpa_pkg::CMD_W;

    typedef struct packed {
        logic [rpa_pkg::STATUS_W-1:0] status;
        logic [rpa_pkg::PAGE_W-1:0]   page;
        logic [rpa_pkg::REF_W-1:0]    count;
        logic                         released;
    } t_response;

    // ------------------------------------------------------------------
    // Scoreboard: predicts each accepted request, checks each response.
    // ------------------------------------------------------------------
    class page_ledger;
        bit [rpa_pkg::REF_W-1:0]  page_counts [NUM_PAGES];
        bit [rpa_pkg::PAGE_W-1:0] free_stack [$];
        bit [rpa_pkg::PAGE_W-1:0] live_pages [$];
        t_response                awaited [$];
        int unsigned              untouched_top;
        bit [rpa_pkg::PAGE_W-1:0] first_free;
        int unsigned              accepted;
        int unsigned              mismatches;
        int unsigned              releases;
        int unsigned              status_seen [CMD_CODES];

        function new();
            untouched_top = NUM_PAGES;
            first_free    = '0;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        function int unsigned stack_depth();
            return free_stack.size();
        endfunction

        function bit [rpa_pkg::REF_W-1:0] count_of(bit [rpa_pkg::PAGE_W-1:0] pg);
            return page_counts[pg];
        endfunction

        // recently handed-out page, or any page when none is known
        function bit [rpa_pkg::PAGE_W-1:0] pick_live();
            if (live_pages.size() == 0) begin
                return rpa_pkg::PAGE_W'($urandom_range(0, NUM_PAGES - 1));
            end
            return live_pages[$urandom_range(0, live_pages.size() - 1)];
        endfunction

        function t_response apply_command(logic [rpa_pkg::CMD_W-1:0] cmd,
                                          logic [rpa_pkg::PAGE_W-1:0] pg);
            t_response                r;
            bit [rpa_pkg::PAGE_W-1:0] got;
            bit [rpa_pkg::REF_W-1:0]  c;
            r        = '0;
            r.status = rpa_pkg::STS_OK;
            r.page   = pg;
            if (cmd == rpa_pkg::CMD_ALLOC) begin
                if (free_stack.size() > 0) begin
                    got = free_stack.pop_back();
                end else if (untouched_top > first_free) begin
                    untouched_top--;
                    got = rpa_pkg::PAGE_W'(untouched_top);
                end else begin
                    r.status = rpa_pkg::STS_EMPTY;
                    r.page   = '0;
                    return r;
                end
                page_counts[got] = 1;
                r.page  = got;
                r.count = 1;
                live_pages.push_back(got);
                if (live_pages.size() > LIVE_DEPTH) begin
                    void'(live_pages.pop_front());
                end
                return r;
            end
            if (int'(pg) >= NUM_PAGES || (cmd == rpa_pkg::CMD_FREE && pg < first_free)) begin
                r.status = rpa_pkg::STS_BAD_PAGE;
                return r;
            end
            c = page_counts[pg];
            case (cmd)
                rpa_pkg::CMD_FREE: begin
                    if (c == 0) begin
                        r.status = rpa_pkg::STS_ZERO;
                    end else begin
                        c--;
                        page_counts[pg] = c;
                        if (c == 0 && free_stack.size() < NUM_PAGES) begin
                            free_stack.push_back(pg);
                            r.released = 1'b1;
                        end else begin
                            r.count = c;
                        end
                    end
                end
                rpa_pkg::CMD_INCR: begin
                    if (c == COUNT_MAX) begin
                        r.status = rpa_pkg::STS_SATURATED;
                        r.count  = c;
                    end else begin
                        c++;
                        page_counts[pg] = c;
                        r.count = c;
                    end
                end
                rpa_pkg::CMD_DECR: begin
                    if (c == 0) begin
                        r.status = rpa_pkg::STS_ZERO;
                    end else begin
                        c--;
                        page_counts[pg] = c;
                        r.count = c;
                    end
                end
                default: begin
                    r.count = c;
                end
            endcase
            return r;
        endfunction

        function void note_request(logic [rpa_pkg::CMD_W-1:0] cmd,
                                   logic [rpa_pkg::PAGE_W-1:0] pg);
            awaited.push_back(apply_command(cmd, pg));
            accepted++;
        endfunction

        function void check_response(logic [31:0] data);
            t_response want;
            t_response got;
            got.status   = data[rpa_pkg::STATUS_W-1:0];
            got.page     = data[rpa_pkg::STATUS_W +: rpa_pkg::PAGE_W];
            got.count    = data[rpa_pkg::STATUS_W + rpa_pkg::PAGE_W +: rpa_pkg::REF_W];
            got.released = data[rpa_pkg::STATUS_W + rpa_pkg::PAGE_W + rpa_pkg::REF_W];
            if (awaited.size() == 0) begin
                $error("response with no request outstanding: tdata %h", data);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            status_seen[want.status]++;
            if (want.released) begin
                releases++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.page !== want.page) begin
                $error("result_page: expected %0d, got %0d", want.page, got.page);
                mismatches++;
            end
            if (got.count !== want.count) begin
                $error("ref_count: expected %0d, got %0d", want.count, got.count);
                mismatches++;
            end
            if (got.released !== want.released) begin
                $error("page_released: expected %0d, got %0d", want.released,
                       got.released);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block under test
    // ------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [14:0] cfg_wr_data = '0;
    logic        s_valid     = 1'b0;
    logic [23:0] s_data      = '0;
    logic        m_ready     = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;

    page_ledger  ledger = new();
    bit          calm = 1'b0;      // both sides stop idling while set
    int unsigned sent = 0;
    int unsigned settings = 0;
    int unsigned cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    refcounted_page_allocator #(
        .NUM_PAGES   (NUM_PAGES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_valid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (s_data),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (m_ready),
        .o_m_tdata     (o_m_tdata)
    );

    // Sample both handshakes on the rising edge, before the block updates.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && o_s_tready) begin
                ledger.note_request(s_data[rpa_pkg::CMD_W-1:0],
                                    s_data[rpa_pkg::CMD_W +: rpa_pkg::PAGE_W]);
            end
            if (o_m_tvalid && m_ready) begin
                ledger.check_response(o_m_tdata);
            end
        end
    end

    // Watchdog: covers the clearing pass plus every request at its slowest.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("refcounted_page_allocator regression: fail");
            $finish;
        end
    end

    // Response side: stall a random number of cycles before each response.
    initial begin : response_sink
        int unsigned stall;
        forever begin
            @(negedge i_clk);
            stall = calm ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Hold one request until accepted; return on the following falling edge.
    task automatic send_request(input logic [rpa_pkg::CMD_W-1:0] cmd,
                                input logic [rpa_pkg::PAGE_W-1:0] pg);
        int unsigned gap;
        if ($urandom_range(0, 49) == 0) begin
            calm = !calm;
        end
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {{(24 - rpa_pkg::CMD_W - rpa_pkg::PAGE_W){1'b0}}, pg, cmd};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    // Drop valid, drain every response, then write first_free_page.
    task automatic set_first_free(input logic [rpa_pkg::PAGE_W-1:0] value);
        s_valid <= 1'b0;
        while (ledger.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        ledger.first_free = value;
        settings++;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Push one page's count past the maximum so saturation shows up.
    task automatic saturate_page(input logic [rpa_pkg::PAGE_W-1:0] pg);
        int unsigned steps;
        steps = COUNT_MAX - ledger.count_of(pg) + $urandom_range(1, 3);
        repeat (steps) send_request(rpa_pkg::CMD_INCR, pg);
    endtask

    // Mostly well-formed traffic on pages handed out recently, plus noise.
    task automatic random_request();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll == 0 && $urandom_range(0, 3) == 0) begin
            saturate_page(ledger.pick_live());
        end else if (roll < 25) begin
            send_request(rpa_pkg::CMD_ALLOC, rpa_pkg::PAGE_W'($urandom));
        end else if (roll < 50) begin
            send_request(rpa_pkg::CMD_FREE, ledger.pick_live());
        end else if (roll < 62) begin
            send_request(rpa_pkg::CMD_INCR, ledger.pick_live());
        end else if (roll < 74) begin
            send_request(rpa_pkg::CMD_DECR, ledger.pick_live());
        end else if (roll < 84) begin
            send_request(rpa_pkg::CMD_READ, ledger.pick_live());
        end else begin
            send_request(rpa_pkg::CMD_W'($urandom_range(0, CMD_CODES - 1)),
                         rpa_pkg::PAGE_W'($urandom_range(0, NUM_PAGES - 1)));
        end
    endtask

    task automatic run_random(input int unsigned upto);
        while (sent < upto) random_request();
    endtask

    initial begin : stimulus
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // the block clears its count table first; the first request waits on tready
        set_first_free('0);

        // directed: fresh table, frontier counts down from the top page
        send_request(rpa_pkg::CMD_READ, '0);
        send_request(rpa_pkg::CMD_READ, TOP_PAGE);
        send_request(rpa_pkg::CMD_ALLOC, TOP_PAGE);     // takes the top page
        send_request(rpa_pkg::CMD_ALLOC, '0);           // next page down
        send_request(rpa_pkg::CMD_INCR, TOP_PAGE);
        send_request(rpa_pkg::CMD_DECR, TOP_PAGE);
        send_request(rpa_pkg::CMD_FREE, TOP_PAGE);      // count reaches zero, pushed
        send_request(rpa_pkg::CMD_FREE, TOP_PAGE);      // already zero
        send_request(rpa_pkg::CMD_DECR, TOP_PAGE);      // already zero
        send_request(rpa_pkg::CMD_ALLOC, '0);           // popped back off the stack
        send_request(rpa_pkg::CMD_DECR, TOP_PAGE - 1);  // reaches zero, not pushed
        send_request(rpa_pkg::CMD_FREE, TOP_PAGE - 1);  // already zero
        send_request(rpa_pkg::CMD_FREE, '0);
        send_request(rpa_pkg::CMD_INCR, '0);            // count commands need no alloc
        send_request(rpa_pkg::CMD_READ, '0);
        for (int c = CMD_SPARE_FIRST; c < CMD_CODES; c++) begin
            send_request(rpa_pkg::CMD_W'(c), '0);
        end
        send_request(rpa_pkg::CMD_INCR, 15'h5555);
        send_request(rpa_pkg::CMD_READ, 15'h2aaa);
        send_request(rpa_pkg::CMD_FREE, TOP_PAGE);
        send_request(rpa_pkg::CMD_ALLOC, TOP_PAGE);
        saturate_page(TOP_PAGE);
        run_random(520);

        // highest setting: frees below it are bad pages, the frontier is spent
        set_first_free(TOP_PAGE);
        send_request(rpa_pkg::CMD_FREE, '0);
        send_request(rpa_pkg::CMD_FREE, TOP_PAGE - 1);
        send_request(rpa_pkg::CMD_INCR, 15'd3);
        repeat (ledger.stack_depth() + 2) begin
            send_request(rpa_pkg::CMD_ALLOC, rpa_pkg::PAGE_W'($urandom));
        end
        run_random(720);

        // just under the frontier so it runs dry partway through
        set_first_free(ledger.untouched_top > 24 ?
                       rpa_pkg::PAGE_W'(ledger.untouched_top - 24) : '0);
        run_random(970);

        set_first_free(rpa_pkg::PAGE_W'($urandom_range(1, NUM_PAGES - 2)));
        run_random(1160);

        set_first_free('0);
        run_random(ITEMS);

        s_valid <= 1'b0;
        while (ledger.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES * 2) @(negedge i_clk);

        $display("%0d requests checked over %0d first_free_page settings, %0d releases",
                 ledger.accepted, settings, ledger.releases);
        $display("statuses: ok %0d, out of pages %0d, bad page %0d, zero %0d, saturated %0d",
                 ledger.status_seen[rpa_pkg::STS_OK], ledger.status_seen[rpa_pkg::STS_EMPTY],
                 ledger.status_seen[rpa_pkg::STS_BAD_PAGE],
                 ledger.status_seen[rpa_pkg::STS_ZERO],
                 ledger.status_seen[rpa_pkg::STS_SATURATED]);
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("refcounted_page_allocator regression: pass");
        end else begin
            $display("refcounted_page_allocator regression: fail");
        end
        $finish;
    end

endmodule
